// ----- hdl/sds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse-to-dense scatter package
// Sizes, codes and shared types for the scatter engine and its lanes.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MAX_RANK    = 4;
    localparam int NUM_DIMS    = 4;
    localparam int DIM_IDX_W   = $clog2(NUM_DIMS);
    localparam int LANES       = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;
    localparam int LIDX_W      = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int RANK_W      = 3;
    localparam int DIM_W       = 13;
    localparam int DATA_W      = 32;
    localparam int COORD_W     = 32;
    localparam int CNT_W       = ADDR_W + 1;
    localparam int CFG_IDX_W   = 3;
    localparam int STAT_W      = 2;
    localparam int OP_W        = 2;

    // saturated product value, one above the store depth
    localparam logic [CNT_W-1:0] SHAPE_SAT = CNT_W'(STORE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_RANK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_SCATTER = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_BOUND = 2'd1,
        ST_SHAPE = 2'd2,
        ST_SKIP  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHAPE,
        S_LANE,
        S_MERGE,
        S_WRITE,
        S_FILL,
        S_READ,
        S_RDATA,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               en;
        logic [COORD_W-1:0] coord;
        logic [DIM_W-1:0]   dim;
        logic [CNT_W-1:0]   stride;
    } t_lane_req;

    typedef struct packed {
        logic              inb;
        logic [ADDR_W-1:0] term;
    } t_lane_res;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
    } t_merge_res;

endpackage
`default_nettype wire

// ----- hdl/sds_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scatter coordinate lane
// Bound check of one coordinate and its stride-weighted address term.
// ----------------------------------------------------------------------------
module sds_lane
    import sds_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_lane_req i_req,
    output t_lane_res      o_res
);

    t_lane_res                r_res;
    logic                     w_inb;
    logic [ADDR_W+CNT_W-1:0]  w_prod;

    always_comb begin
        w_inb  = !i_req.coord[COORD_W-1] &&
                 (i_req.coord[COORD_W-2:0] < (COORD_W-1)'(i_req.dim));
        w_prod = i_req.coord[ADDR_W-1:0] * i_req.stride;
    end

    // unused lanes pass as in bound with no contribution
    always_ff @(posedge i_clk) begin
        r_res.inb  <= w_inb || !i_req.en;
        r_res.term <= i_req.en ? w_prod[ADDR_W-1:0] : '0;
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ----- hdl/sds_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scatter lane merge
// Sum of the lane terms into the linear address and the joint bound flag.
// ----------------------------------------------------------------------------
module sds_merge
    import sds_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_lane_res i_lane [LANES],
    output t_merge_res     o_res
);

    t_merge_res r_res;
    t_merge_res w_sum;

    always_comb begin
        w_sum = '{ok: 1'b1, addr: '0};
        for (int i = 0; i < LANES; i++) begin
            w_sum.ok   = w_sum.ok && i_lane[i].inb;
            w_sum.addr = w_sum.addr + i_lane[i].term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= w_sum;
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ----- hdl/sparse_to_dense_scatter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse-to-dense scatter engine
// Builds a dense row-major tensor in an internal store from sparse requests.
//
// Input channel i_valid / o_stall carries one request: clear, scatter or read.
// Output channel o_valid / i_stall returns one result per request, in order.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// One request is worked on at a time; its steps from acceptance to result:
//   read             store read, read data, output
//   scatter          stride sequencer, lanes, merge, store write, output
//   clear            stride sequencer, lanes, fill of the words (product of
//                    sizes when it fits and is nonzero), output
//   unused op code   output
// The sequencer does one multiply per dimension; the fill uses the single write port.
// The output register holds a finished result while i_stall is high; the
// next request waits in its last step until that register is free.
// Reset restores the configuration defaults, clears the error latch and the
// shape-valid flag; store contents stay undefined until the first clear.
// ----------------------------------------------------------------------------
module sparse_to_dense_scatter
    import sds_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [COORD_W-1:0]   i_coord_0,
    input  wire logic [COORD_W-1:0]   i_coord_1,
    input  wire logic [COORD_W-1:0]   i_coord_2,
    input  wire logic [COORD_W-1:0]   i_coord_3,
    input  wire logic [DATA_W-1:0]    i_entry_value,
    input  wire logic [ADDR_W-1:0]    i_read_address,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [STAT_W-1:0]         o_status,
    output logic [ADDR_W-1:0]         o_address,
    output logic [DATA_W-1:0]         o_data
);

    t_state r_state, n_state;

    logic [RANK_W-1:0]  r_rank;
    logic [DIM_W-1:0]   r_dim [NUM_DIMS];
    logic [DATA_W-1:0]  r_default;

    logic               r_err;
    logic               r_shape_valid;

    t_op                r_op;
    logic [COORD_W-1:0] r_coord [NUM_DIMS];
    logic [ADDR_W-1:0]  r_raddr;

    logic [LIDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]   r_acc;
    logic [CNT_W-1:0]   r_stride [LANES];
    logic [CNT_W-1:0]   r_cnt;

    t_status            r_res_status;
    logic [ADDR_W-1:0]  r_res_addr;
    logic [DATA_W-1:0]  r_res_data;

    logic               r_o_valid;
    t_status            r_o_status;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [DATA_W-1:0]  r_o_data;

    logic [DATA_W-1:0]  mem [STORE_DEPTH];
    logic [DATA_W-1:0]  r_rd_data;

    logic               w_accept;
    logic [RANK_W-1:0]  w_eff_rank;
    logic [CNT_W+DIM_W-1:0] w_acc_mul;
    logic [CNT_W-1:0]   w_acc_next;
    logic               w_shape_big;
    t_status            w_scat_status;
    logic               w_mem_we;
    logic [ADDR_W-1:0]  w_mem_wa;
    logic [DATA_W-1:0]  w_mem_wd;
    logic               w_out_load;

    t_lane_req          w_lane_req [LANES];
    t_lane_res          w_lane_res [LANES];
    t_merge_res         w_merge;

    assign w_accept = i_valid && !o_stall;

    always_comb begin
        if (r_rank == '0) begin
            w_eff_rank = RANK_W'(1);
        end else if (r_rank > RANK_W'(LANES)) begin
            w_eff_rank = RANK_W'(LANES);
        end else begin
            w_eff_rank = r_rank;
        end
    end

    always_comb begin
        w_acc_mul   = r_acc * r_dim[r_idx];
        w_acc_next  = (w_acc_mul > (CNT_W+DIM_W)'(STORE_DEPTH)) ? SHAPE_SAT
                                                                : CNT_W'(w_acc_mul);
        w_shape_big = r_acc > CNT_W'(STORE_DEPTH);
    end

    always_comb begin
        if (!r_shape_valid) begin
            w_scat_status = ST_SHAPE;
        end else if (r_err) begin
            w_scat_status = ST_SKIP;
        end else if (w_shape_big) begin
            w_scat_status = ST_SHAPE;
        end else if (!w_merge.ok) begin
            w_scat_status = ST_BOUND;
        end else begin
            w_scat_status = ST_OK;
        end
    end

    // coordinate lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        always_comb begin
            w_lane_req[g].en     = RANK_W'(g) < w_eff_rank;
            w_lane_req[g].coord  = r_coord[g];
            w_lane_req[g].dim    = r_dim[g];
            w_lane_req[g].stride = r_stride[g];
        end

        sds_lane u_lane (
            .i_clk (i_clk),
            .i_req (w_lane_req[g]),
            .o_res (w_lane_res[g])
        );
    end

    sds_merge u_merge (
        .i_clk  (i_clk),
        .i_lane (w_lane_res),
        .o_res  (w_merge)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_op'(i_op)) inside
                        OP_CLEAR, OP_SCATTER: n_state = S_SHAPE;
                        OP_READ:              n_state = S_READ;
                        default:              n_state = S_OUT;
                    endcase
                end
            end
            S_SHAPE: begin
                if (r_idx == '0) begin
                    n_state = S_LANE;
                end
            end
            S_LANE: begin
                if (r_op == OP_SCATTER) begin
                    n_state = S_MERGE;
                end else if (w_shape_big || r_acc == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_MERGE: n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_FILL: begin
                if (r_cnt == CNT_W'(r_acc - 1'b1)) begin
                    n_state = S_OUT;
                end
            end
            S_READ:  n_state = S_RDATA;
            S_RDATA: n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall    = 1'b1;
        w_mem_we   = 1'b0;
        w_mem_wa   = w_merge.addr;
        w_mem_wd   = r_coord[0];
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: o_stall = 1'b0;
            S_WRITE: begin
                w_mem_we = w_scat_status == ST_OK;
                w_mem_wa = w_merge.addr;
                w_mem_wd = r_res_data;
            end
            S_FILL: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_cnt[ADDR_W-1:0];
                w_mem_wd = r_default;
            end
            S_OUT: w_out_load = !r_o_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rank        <= RANK_W'(1);
            for (int i = 0; i < NUM_DIMS; i++) begin
                r_dim[i] <= DIM_W'(1);
            end
            r_default     <= '0;
            r_err         <= 1'b0;
            r_shape_valid <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index) inside
                    CFG_RANK:              r_rank <= i_cfg_data[RANK_W-1:0];
                    [CFG_DIM_0:CFG_DIM_3]: begin
                        r_dim[DIM_IDX_W'(i_cfg_index - CFG_DIM_0)] <= i_cfg_data[DIM_W-1:0];
                    end
                    CFG_DEFAULT:           r_default <= i_cfg_data;
                    default:               ;
                endcase
            end

            if (r_state == S_LANE && r_op == OP_CLEAR) begin
                r_err         <= 1'b0;
                r_shape_valid <= !w_shape_big;
            end
            if (r_state == S_WRITE && w_scat_status == ST_BOUND) begin
                r_err <= 1'b1;
            end

            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= t_op'(i_op);
            r_coord[0]  <= i_coord_0;
            r_coord[1]  <= i_coord_1;
            r_coord[2]  <= i_coord_2;
            r_coord[3]  <= i_coord_3;
            r_raddr     <= i_read_address;
            r_idx       <= LIDX_W'(w_eff_rank - 1'b1);
            r_acc       <= CNT_W'(1);
            r_res_status <= ST_OK;
            r_res_addr  <= (t_op'(i_op) == OP_READ) ? i_read_address : '0;
            unique case (t_op'(i_op))
                OP_CLEAR:   r_res_data <= r_default;
                OP_SCATTER: r_res_data <= i_entry_value;
                default:    r_res_data <= '0;
            endcase
        end

        if (r_state == S_SHAPE) begin
            r_stride[r_idx] <= r_acc;
            r_acc           <= w_acc_next;
            r_idx           <= r_idx - 1'b1;
        end

        if (r_state == S_LANE) begin
            r_cnt <= '0;
            if (r_op == OP_CLEAR && w_shape_big) begin
                r_res_status <= ST_SHAPE;
            end
        end
        if (r_state == S_FILL) begin
            r_cnt <= r_cnt + 1'b1;
        end

        if (r_state == S_WRITE) begin
            r_res_status <= w_scat_status;
            r_res_addr   <= (w_scat_status == ST_OK) ? w_merge.addr : '0;
        end

        if (r_state == S_RDATA) begin
            r_res_data <= r_rd_data;
        end

        if (w_out_load) begin
            r_o_status <= r_res_status;
            r_o_addr   <= r_res_addr;
            r_o_data   <= r_res_data;
        end
    end

    // dense store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_wa] <= w_mem_wd;
        end
        r_rd_data <= mem[r_raddr];
    end

    assign o_valid   = r_o_valid;
    assign o_status  = r_o_status;
    assign o_address = r_o_addr;
    assign o_data    = r_o_data;

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_mem_we)
        else $error("store written while idle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_cnt < r_acc))
        else $error("fill ran past tensor size");

    a_write_in_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && w_mem_we) |-> (CNT_W'(w_merge.addr) < r_acc))
        else $error("scatter address beyond tensor size");

    a_bound_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && w_scat_status == ST_BOUND) |=> r_err)
        else $error("out-of-bound scatter did not set error");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_o_valid && i_stall) |=> (r_state == S_OUT))
        else $error("result left while output held");

endmodule
`default_nettype wire

// ----- verif/sparse_to_dense_scatter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse-to-dense scatter engine testbench
// Drives clear, scatter and read requests through the valid/stall channels
// with the sender and receiver idling at random, and holds a mirror of the
// dense store, the error latch, the shape flag and the shape registers.
// Every result is compared field by field with the mirrored outcome.
// Directed checks cover reset behaviour, bounds, sticky errors, oversize
// and zero shapes, out-of-range ranks and a full store; a long receiver
// hold-off fills the block, and random traffic runs over many shapes.
// ----------------------------------------------------------------------------
module sparse_to_dense_scatter_test
    import sds_pkg::*;
();

    localparam int LONG_HOLD = 200;

    typedef struct packed {
        t_op                     op;
        logic [3:0][COORD_W-1:0] coord;
        logic [DATA_W-1:0]       value;
        logic [ADDR_W-1:0]       raddr;
    } t_scatter_request;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } t_dense_outcome;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [DATA_W-1:0]    i_cfg_data     = '0;
    logic                 i_valid        = 1'b0;
    logic [OP_W-1:0]      i_op           = OP_NONE;
    logic [COORD_W-1:0]   i_coord_0      = '0;
    logic [COORD_W-1:0]   i_coord_1      = '0;
    logic [COORD_W-1:0]   i_coord_2      = '0;
    logic [COORD_W-1:0]   i_coord_3      = '0;
    logic [DATA_W-1:0]    i_entry_value  = '0;
    logic [ADDR_W-1:0]    i_read_address = '0;
    logic                 i_stall        = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [STAT_W-1:0]    o_status;
    logic [ADDR_W-1:0]    o_address;
    logic [DATA_W-1:0]    o_data;

    // mirror of the block
    logic [DATA_W-1:0]        mirror_store [STORE_DEPTH];
    bit                       mirror_written [STORE_DEPTH];
    int unsigned              written_addrs [$];
    bit                       mirror_error    = 1'b0;
    bit                       mirror_shape_ok = 1'b0;
    logic [RANK_W-1:0]        cfg_rank = 3'd1;
    logic [3:0][DIM_W-1:0]    cfg_dim  = {4{13'd1}};
    logic [DATA_W-1:0]        cfg_fill = '0;

    t_dense_outcome outcomes_due [$];
    int             op_seen [4];
    int             results_seen   = 0;
    int             mismatches     = 0;
    int             shape_settings = 0;
    int             send_idle_pct  = 0;
    int             stall_pct      = 0;
    int             hold_requests  = 0;
    int             hold_served    = 0;
    int             hold_left      = 0;

    sparse_to_dense_scatter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_coord_0      (i_coord_0),
        .i_coord_1      (i_coord_1),
        .i_coord_2      (i_coord_2),
        .i_coord_3      (i_coord_3),
        .i_entry_value  (i_entry_value),
        .i_read_address (i_read_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_address      (o_address),
        .o_data         (o_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #15_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------- mirror

    function automatic int unsigned used_rank();
        int unsigned r;
        r = cfg_rank;
        if (r < 1) r = 1;
        if (r > MAX_RANK) r = MAX_RANK;
        if (r > NUM_DIMS) r = NUM_DIMS;
        return r;
    endfunction

    function automatic longint unsigned shape_extent();
        longint unsigned p;
        int unsigned     k;
        p = 1;
        for (k = 0; k < used_rank(); k++) p = p * cfg_dim[k];
        return p;
    endfunction

    function automatic void store_word(input int unsigned a,
            input logic [DATA_W-1:0] w);
        mirror_store[a] = w;
        if (!mirror_written[a]) begin
            mirror_written[a] = 1'b1;
            written_addrs.push_back(a);
        end
    endfunction

    function automatic t_dense_outcome predict_request(input t_scatter_request rq);
        t_dense_outcome  o;
        longint unsigned extent;
        longint unsigned lin;
        longint unsigned k;
        logic [COORD_W-1:0] c;
        bit              inb;
        extent    = shape_extent();
        o.status  = ST_OK;
        o.address = '0;
        o.data    = '0;
        case (rq.op)
            OP_CLEAR: begin
                mirror_error = 1'b0;
                o.data       = cfg_fill;
                if (extent > STORE_DEPTH) begin
                    mirror_shape_ok = 1'b0;
                    o.status        = ST_SHAPE;
                end else begin
                    for (k = 0; k < extent; k++) store_word(32'(k), cfg_fill);
                    mirror_shape_ok = 1'b1;
                end
            end
            OP_SCATTER: begin
                o.data = rq.value;
                if (!mirror_shape_ok) begin
                    o.status = ST_SHAPE;
                end else if (mirror_error) begin
                    o.status = ST_SKIP;
                end else if (extent > STORE_DEPTH) begin
                    o.status = ST_SHAPE;
                end else begin
                    inb = 1'b1;
                    lin = 0;
                    for (k = 0; k < used_rank(); k++) begin
                        c = rq.coord[k];
                        if (inb) begin
                            if (c[COORD_W-1] || c >= cfg_dim[k]) inb = 1'b0;
                            else lin = lin * cfg_dim[k] + c;
                        end
                    end
                    if (!inb) begin
                        mirror_error = 1'b1;
                        o.status     = ST_BOUND;
                    end else begin
                        store_word(32'(lin), rq.value);
                        o.address = lin[ADDR_W-1:0];
                    end
                end
            end
            OP_READ: begin
                o.address = rq.raddr;
                o.data    = mirror_store[rq.raddr];
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------- requests

    function automatic t_scatter_request make_request(input t_op op,
            input logic [31:0] c0, input logic [31:0] c1, input logic [31:0] c2,
            input logic [31:0] c3, input logic [31:0] value,
            input logic [31:0] raddr);
        t_scatter_request rq;
        rq.op       = op;
        rq.coord[0] = c0;
        rq.coord[1] = c1;
        rq.coord[2] = c2;
        rq.coord[3] = c3;
        rq.value    = value;
        rq.raddr    = raddr[ADDR_W-1:0];
        return rq;
    endfunction

    function automatic t_scatter_request make_blank(input t_op op);
        return make_request(op, $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom());
    endfunction

    function automatic t_scatter_request make_scatter(input bit inbound);
        t_scatter_request rq;
        int unsigned      k;
        int unsigned      bad;
        rq    = make_blank(OP_SCATTER);
        for (k = 0; k < used_rank(); k++) begin
            if (cfg_dim[k] != 0) rq.coord[k] = $urandom_range(cfg_dim[k] - 1, 0);
        end
        if (!inbound) begin
            bad = $urandom_range(used_rank() - 1, 0);
            case ($urandom_range(2, 0))
                0: rq.coord[bad] = $urandom() | 32'h8000_0000;
                1: rq.coord[bad] = cfg_dim[bad] + $urandom_range(3, 0);
                default: rq.coord[bad] = $urandom_range(32'h7FFF_FFFF, 32'h0000_2000);
            endcase
        end
        return rq;
    endfunction

    function automatic t_scatter_request make_read();
        t_scatter_request rq;
        int unsigned      a;
        rq = make_blank(OP_READ);
        a  = $urandom_range(STORE_DEPTH - 1, 0);
        if (!mirror_written[a])
            a = written_addrs[$urandom_range(written_addrs.size() - 1, 0)];
        rq.raddr = a[ADDR_W-1:0];
        return rq;
    endfunction

    task automatic send_request(input t_scatter_request rq);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= rq.op;
        i_coord_0      <= rq.coord[0];
        i_coord_1      <= rq.coord[1];
        i_coord_2      <= rq.coord[2];
        i_coord_3      <= rq.coord[3];
        i_entry_value  <= rq.value;
        i_read_address <= rq.raddr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        outcomes_due.push_back(predict_request(rq));
        op_seen[rq.op]++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_RANK:    cfg_rank = val[RANK_W-1:0];
            CFG_DEFAULT: cfg_fill = val;
            default: begin
                if (idx >= CFG_DIM_0 && idx <= CFG_DIM_3)
                    cfg_dim[DIM_IDX_W'(idx - CFG_DIM_0)] = val[DIM_W-1:0];
            end
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_shape(input int unsigned r, input int unsigned d0,
            input int unsigned d1, input int unsigned d2, input int unsigned d3,
            input logic [31:0] fill);
        logic [31:0] junk;
        // set spare upper bits now and then
        junk = ($urandom_range(3, 0) == 0) ? $urandom() : 32'd0;
        write_register(CFG_RANK, (junk & ~32'h7) | r);
        write_register(CFG_DIM_0, (junk & ~32'h1FFF) | d0);
        write_register(CFG_DIM_0 + 3'd1, (junk & ~32'h1FFF) | d1);
        write_register(CFG_DIM_0 + 3'd2, (junk & ~32'h1FFF) | d2);
        write_register(CFG_DIM_3, (junk & ~32'h1FFF) | d3);
        write_register(CFG_DEFAULT, fill);
        shape_settings++;
    endtask

    task automatic pick_random_shape();
        int unsigned r;
        int unsigned k;
        int unsigned lim;
        int unsigned d [4];
        for (k = 0; k < 4; k++) d[k] = $urandom_range(8191, 0);
        case ($urandom_range(11, 0))
            0: begin
                r = $urandom_range(4, 1);
                for (k = 0; k < r; k++) d[k] = 1 << (12 / r);
            end
            1: begin
                r = $urandom_range(4, 1);
                for (k = 0; k < r; k++) d[k] = (r == 1) ? $urandom_range(8191, 4097)
                                                         : $urandom_range(8191, 65);
            end
            2: begin
                r = $urandom_range(4, 1);
                for (k = 0; k < r; k++) d[k] = $urandom_range(6, 1);
                d[$urandom_range(r - 1, 0)] = 0;
            end
            3: begin
                r = $urandom_range(1, 0) ? 0 : $urandom_range(7, 5);
                for (k = 0; k < ((r == 0) ? 1 : 4); k++) d[k] = $urandom_range(6, 1);
            end
            default: begin
                r = $urandom_range(4, 1);
                case (r)
                    1:       lim = 48;
                    2:       lim = 12;
                    3:       lim = 6;
                    default: lim = 4;
                endcase
                for (k = 0; k < r; k++) d[k] = $urandom_range(lim, 1);
            end
        endcase
        write_shape(r, d[0], d[1], d[2], d[3], $urandom());
    endtask

    task automatic run_setting(input int unsigned n);
        int unsigned roll;
        int unsigned i;
        pick_random_shape();
        send_request(make_blank(OP_CLEAR));
        for (i = 1; i < n; i++) begin
            roll = $urandom_range(99, 0);
            if ((mirror_error && roll < 35) || roll < 3) send_request(make_blank(OP_CLEAR));
            else if (roll < 5) send_request(make_blank(OP_NONE));
            else if (roll < 9) send_request(make_scatter(1'b0));
            else if (roll < 35 && written_addrs.size() != 0) send_request(make_read());
            else send_request(make_scatter(1'b1));
        end
        wait_drained();
    endtask

    // ----------------------------------------------------------------- tests

    task automatic test_reset_state();
        send_request(make_request(OP_SCATTER, 0, 0, 0, 0, 32'h1234_5678, 0));
        send_request(make_blank(OP_NONE));
        send_request(make_blank(OP_CLEAR));
        send_request(make_request(OP_SCATTER, 0, $urandom(), $urandom(), $urandom(),
                                  32'hFFFF_FFFF, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_bounds_and_skip();
        write_shape(4, 4, 3, 2, 5, 32'h8000_0000);
        send_request(make_blank(OP_CLEAR));
        send_request(make_request(OP_SCATTER, 3, 2, 1, 4, 32'h7FFF_FFFF, 0));
        send_request(make_request(OP_SCATTER, 0, 0, 0, 0, 32'h0000_0000, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 119));
        send_request(make_request(OP_SCATTER, 0, 0, 0, 5, $urandom(), 0));
        send_request(make_request(OP_SCATTER, 1, 1, 1, 1, $urandom(), 0));
        send_request(make_blank(OP_CLEAR));
        send_request(make_request(OP_SCATTER, 0, 32'h8000_0000, 0, 0, $urandom(), 0));
        send_request(make_blank(OP_CLEAR));
        send_request(make_request(OP_SCATTER, 32'hFFFF_FFFF, 0, 0, 0, $urandom(), 0));
        wait_drained();
    endtask

    task automatic test_shape_limits();
        write_shape(1, 4096, 8191, 8191, 0, 32'h7FFF_FFFF);
        send_request(make_blank(OP_CLEAR));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 4095));
        send_request(make_request(OP_SCATTER, 4095, $urandom(), $urandom(), $urandom(),
                                  $urandom(), 0));
        wait_drained();
        write_register(CFG_DIM_0, 4097);
        send_request(make_request(OP_SCATTER, 1, 0, 0, 0, $urandom(), 0));
        send_request(make_blank(OP_CLEAR));
        send_request(make_request(OP_SCATTER, 1, 0, 0, 0, $urandom(), 0));
        wait_drained();
        write_shape(2, 0, 7, 1, 1, $urandom());
        send_request(make_blank(OP_CLEAR));
        send_request(make_request(OP_SCATTER, 0, 0, 0, 0, $urandom(), 0));
        wait_drained();
    endtask

    task automatic test_rank_range();
        write_shape(0, 5, 8191, 8191, 8191, $urandom());
        send_request(make_blank(OP_CLEAR));
        send_request(make_request(OP_SCATTER, 4, $urandom(), $urandom(), $urandom(),
                                  $urandom(), 0));
        wait_drained();
        write_shape(7, 2, 2, 2, 2, $urandom());
        send_request(make_blank(OP_CLEAR));
        send_request(make_request(OP_SCATTER, 1, 1, 1, 1, $urandom(), 0));
        wait_drained();
    endtask

    task automatic test_long_backpressure();
        int unsigned i;
        send_idle_pct = 0;
        stall_pct     = 0;
        write_shape(2, 8, 8, $urandom_range(8191, 0), $urandom_range(8191, 0), $urandom());
        send_request(make_blank(OP_CLEAR));
        wait_drained();
        hold_requests <= hold_requests + 1;
        for (i = 0; i < 24; i++) begin
            if (i % 3 == 2) send_request(make_read());
            else send_request(make_scatter(1'b1));
        end
        // hold the sender back until the block has emptied
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned ph;
        int unsigned s;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 53;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 53;
                end
                default: begin
                    send_idle_pct = 12;
                    stall_pct     = 12;
                end
            endcase
            for (s = 0; s < 6; s++) run_setting(58);
        end
    endtask

    // -------------------------------------------------------- result side

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            i_stall     <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_dense_outcome due;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (outcomes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d address %0d data %h",
                             o_status, o_address, o_data);
            end else begin
                due = outcomes_due.pop_front();
                if (o_status !== due.status || o_address !== due.address ||
                        o_data !== due.data) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected status %0d address %0d data %h,",
                                 results_seen, due.status, due.address, due.data);
                        $display("    got status %0d address %0d data %h",
                                 o_status, o_address, o_data);
                    end
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_bounds_and_skip();
        test_shape_limits();
        test_rank_range();
        test_long_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d requests: %0d clear, %0d scatter, %0d read, %0d unused code,",
                 op_seen[OP_CLEAR] + op_seen[OP_SCATTER] + op_seen[OP_READ] + op_seen[OP_NONE],
                 op_seen[OP_CLEAR], op_seen[OP_SCATTER], op_seen[OP_READ], op_seen[OP_NONE]);
        $display("over %0d shapes; compared %0d results, %0d mismatched, %0d words touched",
                 shape_settings, results_seen, mismatches, written_addrs.size());
        if (mismatches == 0 && outcomes_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sparse_to_dense_scatter.f -----
hdl/sds_pkg.sv
hdl/sds_lane.sv
hdl/sds_merge.sv
hdl/sparse_to_dense_scatter.sv
verif/sparse_to_dense_scatter_test.sv
